// ----- rtl/ssdd_pkg.sv -----
package ssdd_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned DIST_W = 15;
  localparam int unsigned CNT_W  = 16;

  localparam logic [7:0]        SEG_MASK        = 8'hFE;
  localparam logic [7:0]        SEG_S           = 8'hB6;
  localparam logic [7:0]        SEG_E           = 8'h9E;
  localparam logic [DIST_W-1:0] DIST_UNKNOWN    = 15'd32767;
  localparam logic [CNT_W-1:0]  COUNT_MAX       = 16'hFFFF;
  localparam logic [CNT_W-1:0]  THRESHOLD_RESET = 16'd150;

  // One result as it sits in the output stage.
  typedef struct packed {
    logic [DIST_W-1:0] distance_value;
    logic              updated;
    logic              stable;
  } result_t;

  // Segment pattern (decimal point already masked) to digit; unknown reads as 0.
  function automatic logic [3:0] seg_to_digit(input logic [7:0] pattern);
    logic [3:0] d;
    unique case (pattern)
      8'hFC:   d = 4'd0;
      8'h60:   d = 4'd1;
      8'hDA:   d = 4'd2;
      8'hF2:   d = 4'd3;
      8'h66:   d = 4'd4;
      8'hB6:   d = 4'd5;
      8'hBE:   d = 4'd6;
      8'hE0:   d = 4'd7;
      8'hFE:   d = 4'd8;
      8'hF6:   d = 4'd9;
      default: d = 4'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/seven_segment_distance_decoder.sv -----
// Seven-segment distance decoder. Each input transfer carries one captured display word
// (left digit in bits 15..8, right digit in bits 7..0, bit 0 of each byte its decimal
// point) and produces exactly one result transfer. The block counts consecutive repeats
// of a nonzero word, saturating at 65535; a zero word clears the count and a different
// word restarts it. Once the count reaches stable_threshold the two digits are decoded
// into a distance: 100*left + 10*right with the left decimal point lit, else
// 1000*left + 100*right. The text "SE" holds the previous distance, and 32767 means no
// distance is known yet. The repeat counter, digit lookup and distance are computed
// in the cycle of the input transfer and land in the output stage, so a new item is
// taken every cycle while results drain. A two-entry output stage (output register
// plus skid register) keeps in_stall a registered signal; it rises only when both
// entries are full. Write stable_threshold only while the block is idle; cfg_ready is
// always high.
module seven_segment_distance_decoder
  import ssdd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [WORD_W-1:0] in_display_word,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DIST_W-1:0] out_distance_value,
  output logic              out_updated,
  output logic              out_stable,
  // configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_stable_threshold
);

  // Control and state registers
  logic [CNT_W-1:0]  threshold_r;
  logic [WORD_W-1:0] last_word_r,  last_word_nxt;
  logic [CNT_W-1:0]  match_cnt_r,  match_cnt_nxt;
  logic [DIST_W-1:0] dist_r,       dist_nxt;
  logic              out_vld_r,    out_vld_nxt;
  logic              skid_vld_r,   skid_vld_nxt;
  result_t           out_data_r,   out_data_nxt;
  result_t           skid_data_r,  skid_data_nxt;

  logic    in_xfer;
  logic    out_xfer;
  result_t res;

  // Decode datapath signals
  logic [7:0]  left_seg;
  logic [7:0]  right_seg;
  logic        left_dp;
  logic [3:0]  left_dig;
  logic [3:0]  right_dig;
  logic [13:0] dist_calc;
  logic        is_se;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_vld_r;
  assign in_xfer   = in_valid & ~skid_vld_r;
  assign out_xfer  = out_vld_r & ~out_stall;

  // Digit decode straight from the incoming word
  assign left_seg  = in_display_word[15:8] & SEG_MASK;
  assign right_seg = in_display_word[7:0] & SEG_MASK;
  assign left_dp   = in_display_word[8];
  assign left_dig  = seg_to_digit(left_seg);
  assign right_dig = seg_to_digit(right_seg);
  assign is_se     = (left_seg == SEG_S) && (right_seg == SEG_E);

  // Constant multiplies only; the largest value is 9900
  always_comb begin
    if (left_dp) begin
      dist_calc = 14'(left_dig) * 14'd100 + 14'(right_dig) * 14'd10;
    end else begin
      dist_calc = 14'(left_dig) * 14'd1000 + 14'(right_dig) * 14'd100;
    end
  end

  // Per-item state update and result
  always_comb begin
    last_word_nxt = last_word_r;
    match_cnt_nxt = match_cnt_r;
    dist_nxt      = dist_r;
    res.updated   = 1'b0;
    res.stable    = 1'b0;

    if (in_display_word == '0) begin
      // blank display: drop the count, keep the word
      match_cnt_nxt = '0;
    end else begin
      if (in_display_word == last_word_r) begin
        // repeat: advance, saturating at the top
        if (match_cnt_r != COUNT_MAX) begin
          match_cnt_nxt = match_cnt_r + 1'b1;
        end
      end else begin
        // new word: restart the count
        match_cnt_nxt = '0;
        last_word_nxt = in_display_word;
      end

      if (match_cnt_nxt >= threshold_r) begin
        res.stable = 1'b1;
        // "SE" on the display: hold the stored distance
        if (!is_se) begin
          dist_nxt    = DIST_W'(dist_calc);
          res.updated = 1'b1;
        end
      end
    end

    res.distance_value = dist_nxt;
  end

  // Output stage: output register fed either by a new item or the skid entry
  always_comb begin
    out_vld_nxt   = out_vld_r;
    skid_vld_nxt  = skid_vld_r;
    out_data_nxt  = out_data_r;
    skid_data_nxt = skid_data_r;

    if (out_xfer) begin
      out_vld_nxt = 1'b0;
    end

    if (skid_vld_r) begin
      // no input transfer can happen while the skid entry is full
      if (out_xfer) begin
        out_vld_nxt  = 1'b1;
        out_data_nxt = skid_data_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (in_xfer) begin
      if (out_vld_r && !out_xfer) begin
        // output still waiting: park the result in the skid entry
        skid_vld_nxt  = 1'b1;
        skid_data_nxt = res;
      end else begin
        out_vld_nxt  = 1'b1;
        out_data_nxt = res;
      end
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      last_word_r <= '0;
      match_cnt_r <= '0;
      dist_r      <= DIST_UNKNOWN;
      out_vld_r   <= 1'b0;
      skid_vld_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        threshold_r <= cfg_stable_threshold;
      end
      if (in_xfer) begin
        last_word_r <= last_word_nxt;
        match_cnt_r <= match_cnt_nxt;
        dist_r      <= dist_nxt;
      end
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid          = out_vld_r;
  assign out_distance_value = out_data_r.distance_value;
  assign out_updated        = out_data_r.updated;
  assign out_stable         = out_data_r.stable;

endmodule

// ----- rtl/ssdd_checker.sv -----
module ssdd_checker
  import ssdd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DIST_W-1:0] out_distance_value,
  input logic              out_updated,
  input logic              out_stable
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_distance_value)
      && $stable(out_updated) && $stable(out_stable))
    else $error("result changed while stalled");

  // A rewrite only happens on an interpreted display
  a_upd_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_updated |-> out_stable)
    else $error("update without stable display");

  // A decoded distance never exceeds two digits times one hundred
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_updated |-> out_distance_value <= 15'd9900)
    else $error("decoded distance out of range");

  // Nothing comes out in the cycle after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output stage not cleared by reset");

endmodule

bind seven_segment_distance_decoder ssdd_checker u_ssdd_checker (.*);

// ----- verif/seven_segment_distance_decoder_test.sv -----
`timescale 1ns / 100ps

module seven_segment_distance_decoder_test;
  import ssdd_pkg::*;

  // Segment patterns of the digits 0..9, decimal point cleared.
  localparam logic [7:0] DIGIT_SEGMENTS [10] = '{
    8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
  };

  // Directed rows either send a display word (possibly repeated) or rewrite the threshold.
  typedef enum logic {ROW_SAMPLE, ROW_THRESHOLD} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [WORD_W-1:0] value;   // display word, or threshold for ROW_THRESHOLD
    logic [31:0]       reps;    // how many times the word is sent back to back
    logic              pinned;  // last repeat is checked against res below
    result_t           res;
  } stim_row_t;

  localparam int NUM_ROWS = 24;

  // Hand-written expectations sit only where the value is obvious; the rest go
  // through the reading predictor.
  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    // blank display right after reset: nothing known yet
    '{ROW_SAMPLE,    16'h0000, 1,     1'b1, '{DIST_UNKNOWN, 1'b0, 1'b0}},
    // "10" seen once: far below the reset threshold
    '{ROW_SAMPLE,    16'h60FC, 1,     1'b1, '{DIST_UNKNOWN, 1'b0, 1'b0}},
    // 150 more repeats reach the reset threshold: 1000
    '{ROW_SAMPLE,    16'h60FC, 150,   1'b1, '{15'd1000, 1'b1, 1'b1}},
    // blank clears the count, keeps the distance
    '{ROW_SAMPLE,    16'h0000, 1,     1'b1, '{15'd1000, 1'b0, 1'b0}},
    // threshold zero: every nonzero word decodes at once
    '{ROW_THRESHOLD, 16'd0,    0,     1'b0, '0},
    '{ROW_SAMPLE,    16'hF6F6, 1,     1'b1, '{15'd9900, 1'b1, 1'b1}},
    '{ROW_SAMPLE,    16'hF7F6, 1,     1'b1, '{15'd990,  1'b1, 1'b1}},
    // "SE" holds the distance, with and without the right decimal point
    '{ROW_SAMPLE,    16'hB69E, 1,     1'b1, '{15'd990,  1'b0, 1'b1}},
    '{ROW_SAMPLE,    16'hB69F, 1,     1'b1, '{15'd990,  1'b0, 1'b1}},
    // the S pattern read as a five
    '{ROW_SAMPLE,    16'hB7F6, 1,     1'b1, '{15'd590,  1'b1, 1'b1}},
    '{ROW_SAMPLE,    16'hB6B6, 1,     1'b0, '0},
    '{ROW_SAMPLE,    16'h9EB6, 1,     1'b0, '0},
    // unknown patterns on both sides decode as zero
    '{ROW_SAMPLE,    16'h0102, 1,     1'b1, '{15'd0,    1'b1, 1'b1}},
    // all ones: 8.8, right decimal point ignored
    '{ROW_SAMPLE,    16'hFFFF, 1,     1'b1, '{15'd880,  1'b1, 1'b1}},
    // walk the remaining digits
    '{ROW_SAMPLE,    16'hFCDA, 1,     1'b0, '0},
    '{ROW_SAMPLE,    16'hF266, 1,     1'b0, '0},
    '{ROW_SAMPLE,    16'hBEE0, 1,     1'b0, '0},
    '{ROW_SAMPLE,    16'hFE61, 1,     1'b0, '0},
    // small threshold: a blank in the middle of a run keeps the stored word
    '{ROW_THRESHOLD, 16'd3,    0,     1'b0, '0},
    '{ROW_SAMPLE,    16'h6061, 4,     1'b0, '0},
    '{ROW_SAMPLE,    16'h0000, 1,     1'b1, '{15'd1100, 1'b0, 1'b0}},
    '{ROW_SAMPLE,    16'h6061, 3,     1'b0, '0},
    // largest threshold: a short run never settles
    '{ROW_THRESHOLD, 16'hFFFF, 0,     1'b0, '0},
    '{ROW_SAMPLE,    16'hDAF2, 2,     1'b1, '{15'd1100, 1'b0, 1'b0}}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [WORD_W-1:0] in_display_word = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DIST_W-1:0] out_distance_value;
  logic              out_updated;
  logic              out_stable;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_stable_threshold = '0;

  // Predictor state, shadowing the block.
  logic [CNT_W-1:0]  pred_threshold = THRESHOLD_RESET;
  logic [WORD_W-1:0] pred_last_word = '0;
  logic [CNT_W-1:0]  pred_match_count = '0;
  logic [DIST_W-1:0] pred_distance = DIST_UNKNOWN;

  result_t expected_readings[$];

  bit idle_on = 1'b1;       // random gaps on both channels
  int long_hold_cycles = 0; // request for one long receiver hold-off

  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned updates_seen = 0;
  int unsigned stable_seen = 0;
  int unsigned holds_seen = 0;
  int unsigned thresholds_written = 0;
  int unsigned input_stall_cycles = 0;

  seven_segment_distance_decoder dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_display_word      (in_display_word),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_distance_value   (out_distance_value),
    .out_updated          (out_updated),
    .out_stable           (out_stable),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_stable_threshold (cfg_stable_threshold)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: far beyond the slowest legal run, stalls and pauses included.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Unknown patterns read as zero.
  function automatic logic [3:0] segments_to_digit(input logic [7:0] pattern);
    for (int d = 0; d < 10; d++) begin
      if (DIGIT_SEGMENTS[d] == pattern) return 4'(d);
    end
    return 4'd0;
  endfunction

  // Advance the shadow state by one display word and return the reading it produces.
  function automatic result_t predict_reading(input logic [WORD_W-1:0] word);
    result_t    r;
    logic [7:0] left_seg;
    logic [7:0] right_seg;
    logic [3:0] left_digit;
    logic [3:0] right_digit;
    r = '0;
    if (word == '0) begin
      pred_match_count = '0;
    end else begin
      if (word == pred_last_word) begin
        if (pred_match_count != COUNT_MAX) pred_match_count = pred_match_count + 1'b1;
      end else begin
        pred_match_count = '0;
        pred_last_word   = word;
      end
      if (pred_match_count >= pred_threshold) begin
        r.stable  = 1'b1;
        left_seg  = word[15:8] & SEG_MASK;
        right_seg = word[7:0] & SEG_MASK;
        if (!(left_seg == SEG_S && right_seg == SEG_E)) begin
          left_digit  = segments_to_digit(left_seg);
          right_digit = segments_to_digit(right_seg);
          // left decimal point lit: d.d meters in centimeters
          if (word[8]) pred_distance = DIST_W'(100 * left_digit + 10 * right_digit);
          else         pred_distance = DIST_W'(1000 * left_digit + 100 * right_digit);
          r.updated = 1'b1;
        end
      end
    end
    r.distance_value = pred_distance;
    return r;
  endfunction

  // Mostly real digits with random decimal points, sometimes "SE" or a junk byte.
  function automatic logic [WORD_W-1:0] pick_display_word();
    logic [7:0] left_seg;
    logic [7:0] right_seg;
    left_seg  = DIGIT_SEGMENTS[$urandom_range(0, 9)] | 8'($urandom_range(0, 1));
    right_seg = DIGIT_SEGMENTS[$urandom_range(0, 9)] | 8'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: begin
        left_seg  = SEG_S | 8'($urandom_range(0, 1));
        right_seg = SEG_E | 8'($urandom_range(0, 1));
      end
      1: left_seg  = 8'($urandom_range(0, 255));
      2: right_seg = 8'($urandom_range(0, 255));
      default: ;
    endcase
    return {left_seg, right_seg};
  endfunction

  // Offer one display word, hold it until the transfer, then queue its expected reading.
  task automatic send_reading(input logic [WORD_W-1:0] word, input bit pinned,
                              input result_t pinned_res);
    result_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_display_word <= word;
    do @(posedge clk); while (in_stall);
    predicted = predict_reading(word);
    expected_readings.push_back(pinned ? pinned_res : predicted);
    items_sent++;
  endtask

  // Drop valid and wait until every queued reading has come back.
  task automatic wait_all_readings();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_readings.size() != 0);
  endtask

  // Rewrite the threshold with the block idle.
  task automatic write_threshold(input logic [CNT_W-1:0] value);
    wait_all_readings();
    cfg_valid            <= 1'b1;
    cfg_stable_threshold <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid      <= 1'b0;
    pred_threshold = value;
    thresholds_written++;
  endtask

  // Receiver: random stall bursts while idling is on, plus the one long hold-off on request.
  initial begin : reading_sink
    int n;
    forever begin
      @(posedge clk);
      if (long_hold_cycles != 0) begin
        n = long_hold_cycles;
        long_hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Check every result transfer against the oldest queued reading.
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && in_valid && in_stall) input_stall_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected reading: distance_value %0d updated %0b stable %0b",
               out_distance_value, out_updated, out_stable);
        error_count++;
      end else begin
        exp_r = expected_readings.pop_front();
        results_seen++;
        if (exp_r.updated) updates_seen++;
        if (exp_r.stable) stable_seen++;
        if (exp_r.stable && !exp_r.updated) holds_seen++;
        if (out_distance_value !== exp_r.distance_value) begin
          $error("distance_value: expected %0d, got %0d", exp_r.distance_value,
                 out_distance_value);
          error_count++;
        end
        if (out_updated !== exp_r.updated) begin
          $error("updated: expected %0b, got %0b", exp_r.updated, out_updated);
          error_count++;
        end
        if (out_stable !== exp_r.stable) begin
          $error("stable: expected %0b, got %0b", exp_r.stable, out_stable);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [WORD_W-1:0] word;
    int unsigned       phase_start;
    int unsigned       run_len;
    int unsigned       kind;
    bit                paused;
    paused = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, with idling on both sides.
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_THRESHOLD) begin
        write_threshold(DIRECTED[i].value);
      end else begin
        idle_on = 1'b1;
        for (int unsigned k = 1; k <= DIRECTED[i].reps; k++) begin
          send_reading(DIRECTED[i].value, DIRECTED[i].pinned && k == DIRECTED[i].reps,
                       DIRECTED[i].res);
        end
      end
    end

    // Random phases, each under its own small threshold; the last one runs flat out.
    for (int phase = 0; phase < 6; phase++) begin
      write_threshold(phase == 0 ? CNT_W'(1) : CNT_W'($urandom_range(0, 6)));
      idle_on     = (phase != 5) && (phase % 2 == 0 || $urandom_range(0, 1) == 1);
      phase_start = items_sent;
      // keep offering while the receiver sits still, so the block backs up
      if (phase == 2) long_hold_cycles = 60;
      while (items_sent - phase_start < 55) begin
        if (phase == 3 && !paused && items_sent - phase_start >= 28) begin
          wait_all_readings();
          paused = 1'b1;
        end
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          // well-formed run long enough to settle, or a broken short one
          word    = pick_display_word();
          run_len = (kind == 6) ? $urandom_range(1, pred_threshold + 1)
                                : pred_threshold + 1 + $urandom_range(0, 2);
          repeat (run_len) send_reading(word, 1'b0, '0);
          if ($urandom_range(0, 2) == 0) send_reading('0, 1'b0, '0);
        end else if (kind < 9) begin
          send_reading(WORD_W'($urandom_range(0, 65535)), 1'b0, '0);
        end else begin
          send_reading('0, 1'b0, '0);
        end
      end
    end

    // Let the last readings drain, then watch a little longer for strays.
    wait_all_readings();
    repeat (20) @(posedge clk);

    $display("Sent %0d display words under %0d threshold writes, stalls and a full block",
             items_sent, thresholds_written);
    $display("Readings: %0d checked, %0d stable, %0d updates, %0d SE holds, %0d stall cycles",
             results_seen, stable_seen, updates_seen, holds_seen, input_stall_cycles);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
